// ----- hw/rtl/itoa_pkg.sv -----
// Shared types and constants for the integer to ASCII formatter.
// No dependencies; imported by every module of the block.
`default_nettype none

package itoa_pkg;

    localparam int ValueWidth = 32;
    localparam int MaxDigits  = ValueWidth;
    localparam int DepthWidth = $clog2(MaxDigits + 1);
    localparam int CharWidth  = 8;
    localparam int CountWidth = 32;
    localparam int DigitWidth = 4;

    localparam logic [31:0] DecRecip = 32'hCCCC_CCCD;
    localparam int          DecShift = 35;

    localparam logic [CharWidth-1:0] CharZero  = 8'h30;
    localparam logic [CharWidth-1:0] CharMinus = 8'h2D;

    typedef enum logic [1:0] {
        OP_SDEC = 2'd0,
        OP_UDEC = 2'd1,
        OP_BIN  = 2'd2,
        OP_OCT  = 2'd3
    } op_e;

    typedef struct packed {
        logic load;
        logic step;
        logic emit_sign;
        logic emit_digit;
    } itoa_cmd_t;

    typedef struct packed {
        logic quot_zero;
        logic neg;
        logic stack_empty;
        logic last_digit;
        logic out_free;
    } itoa_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/itoa_datapath.sv -----
// Datapath: working value, digit extraction, digit stack and output register.
// Depends on itoa_pkg; driven by itoa_control through itoa_cmd_t.
`default_nettype none

module itoa_datapath
    import itoa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire itoa_cmd_t             cmd,
    output itoa_stat_t                 stat,
    input  wire op_e                   in_op,
    input  wire logic [ValueWidth-1:0] in_value,
    output logic [CharWidth-1:0]       out_char,
    output logic                       out_last,
    output logic [CountWidth-1:0]      out_total,
    output logic                       out_valid,
    input  wire logic                  out_ready
);

    op_e                    op_reg;
    logic                   neg_reg;
    logic [ValueWidth-1:0]  work_reg;
    logic [DigitWidth-1:0]  stack_reg [MaxDigits];
    logic [DepthWidth-1:0]  depth_reg;
    logic [CountWidth-1:0]  total_reg;
    logic [CharWidth-1:0]   char_reg;
    logic                   last_reg;
    logic                   valid_reg;

    logic [63:0]            prod;
    logic [ValueWidth-1:0]  quot;
    logic [ValueWidth-1:0]  quot10;
    logic [DigitWidth-1:0]  digit;
    logic                   in_neg;

    always_comb begin
        prod   = {32'b0, work_reg} * {32'b0, DecRecip};
        quot10 = '0;
        case (op_reg)
            OP_BIN: begin
                quot  = work_reg >> 1;
                digit = {3'b0, work_reg[0]};
            end
            OP_OCT: begin
                quot  = work_reg >> 3;
                digit = {1'b0, work_reg[2:0]};
            end
            default: begin
                quot   = {3'b0, prod[63:DecShift]};
                quot10 = (quot << 3) + (quot << 1);
                digit  = work_reg[3:0] - quot10[3:0];
            end
        endcase
    end

    assign in_neg = (in_op == OP_SDEC) && in_value[ValueWidth-1];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            neg_reg  <= in_neg;
            work_reg <= in_neg ? (~in_value + 1'b1) : in_value;
        end else if (cmd.step) begin
            work_reg <= quot;
        end
        if (cmd.step) begin
            stack_reg[0] <= digit;
            for (int i = 1; i < MaxDigits; i++) begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end else if (cmd.emit_digit) begin
            for (int i = 0; i < MaxDigits - 1; i++) begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
        if (cmd.emit_sign) begin
            char_reg <= CharMinus;
            last_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            char_reg <= CharZero + {4'b0, stack_reg[0]};
            last_reg <= (depth_reg == DepthWidth'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            total_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                depth_reg <= '0;
            end else if (cmd.step) begin
                depth_reg <= depth_reg + 1'b1;
            end else if (cmd.emit_digit) begin
                depth_reg <= depth_reg - 1'b1;
            end
            if (cmd.emit_sign || cmd.emit_digit) begin
                total_reg <= total_reg + 1'b1;
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign stat.quot_zero   = (quot == '0);
    assign stat.neg         = neg_reg;
    assign stat.stack_empty = (depth_reg == '0);
    assign stat.last_digit  = (depth_reg == DepthWidth'(1));
    assign stat.out_free    = !valid_reg || out_ready;

    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign out_total = total_reg;
    assign out_valid = valid_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> depth_reg < DepthWidth'(MaxDigits))
        else $error("digit stack overflow");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_digit |-> depth_reg != '0)
        else $error("digit pop from empty stack");
    a_sign_first: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_sign |-> neg_reg && depth_reg != '0)
        else $error("minus sign emitted out of order");

endmodule

`default_nettype wire

// ----- hw/rtl/itoa_control.sv -----
// Controller state machine: accept, convert digit by digit, emit characters.
// Depends on itoa_pkg; commands itoa_datapath.
`default_nettype none

module itoa_control
    import itoa_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire itoa_stat_t stat,
    output itoa_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONVERT,
        S_SIGN,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CONVERT;
                end
            end
            S_CONVERT: begin
                cmd.step = 1'b1;
                if (stat.quot_zero) begin
                    state_next = stat.neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (stat.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (stat.last_digit) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> stat.stack_empty)
        else $error("digits left over in idle");
    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command");
    a_emit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_sign || cmd.emit_digit) |-> stat.out_free)
        else $error("character emitted over a held beat");
    a_load_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == S_IDLE && in_valid)
        else $error("load outside idle");

endmodule

`default_nettype wire

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
// Top level of the integer to ASCII formatter.
// Depends on itoa_pkg, itoa_control and itoa_datapath.
//
// Formats a 32-bit value as ASCII, most significant character first with no
// leading zeros: signed decimal, unsigned decimal, binary or octal, chosen by
// s_axis_tuser. Each output beat carries one character, tlast on the final
// character and the running character count (wrapping at 2^32). An item is
// accepted only in idle. Its digits go into the digit stack one per cycle, from
// the reciprocal-multiply divide unit for decimal or by shifts for binary and
// octal; then a minus sign, if any, and the digits are popped one per cycle into
// the output register while the output is not held. At most 32 digits (binary).
`default_nettype none

module integer_to_ascii_formatter
    import itoa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] value
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // [7:0] character, [39:8] char_total
    output logic             m_axis_tlast
);

    itoa_cmd_t              cmd;
    itoa_stat_t             stat;
    logic [CharWidth-1:0]   out_char;
    logic [CountWidth-1:0]  out_total;

    itoa_control u_control (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    itoa_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (op_e'(s_axis_tuser)),
        .in_value  (s_axis_tdata[ValueWidth-1:0]),
        .out_char  (out_char),
        .out_last  (m_axis_tlast),
        .out_total (out_total),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {out_total, out_char};

endmodule

`default_nettype wire
